// ===== hdl/dfls_pkg.sv =====
// Shared types, codes and constants of the decision forest leaf search block.
// No dependencies; every other file imports this package.
package dfls_pkg;

	// Default sizes of the stores and the walk bound
	localparam int NODE_SLOTS_DEF    = 65536;
	localparam int FEATURE_SLOTS_DEF = 4096;
	localparam int SAMPLE_WORDS_DEF  = 262144;
	localparam int MAX_DEPTH_DEF     = 64;

	// Number of trees the tree index is folded into
	localparam int TREE_COUNT = 8;

	// Sum of an 18-bit offset and an 18-bit patch base
	localparam int    SUM_W     = 19;
	localparam longint SUM_LIMIT = longint'(1) << SUM_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODES_PER_TREE   = 1'b0,
		CFG_CHANNEL_FEATURES = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FUNC_LOAD_NODE    = 2'd0,
		FUNC_LOAD_OFFSETS = 2'd1,
		FUNC_WRITE_SAMPLE = 2'd2,
		FUNC_EVALUATE     = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [15:0]        node_index;
		logic [15:0]        child_link;
		logic [11:0]        feature_id;
		logic signed [23:0] threshold;
		logic [17:0]        offset_a;
		logic [17:0]        offset_b;
		logic               sample_select;
		logic [17:0]        sample_address;
		logic signed [23:0] sample_value;
		logic [17:0]        patch_offset;
		logic [2:0]         tree_index;
	} req_t;

	typedef struct packed {
		logic [15:0] leaf_index;
		logic        depth_overrun;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        child;
		logic [11:0]        feat;
		logic signed [23:0] thr;
	} node_t;

	typedef struct packed {
		logic [17:0] a;
		logic [17:0] b;
	} offset_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NODE_RD,
		ST_NODE_CHK,
		ST_ADDR,
		ST_MOD,
		ST_SMP_RD,
		ST_CMP,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;     // request taken this cycle
		logic eval_load;  // evaluate request: latch tree base and patch
		logic node_rd;    // read node at current slot
		logic off_rd;     // read offset pair of current node's feature
		logic addr_init;  // form offset + patch sums
		logic mod_step;   // one conditional subtract of the address fold
		logic smp_rd;     // read samples
		logic advance;    // compare and move to child
		logic set_ovr;    // mark depth overrun
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_leaf;
		logic depth_hit;
	} ctrl_status_t;

	// Conditional subtract steps that bring a sum below the sample depth
	function automatic int mod_steps(input int words);
		int n;
		n = 0;
		for (int i = 0; i < 32; i++) begin
			if ((longint'(words) << n) < SUM_LIMIT) n++;
		end
		return n;
	endfunction

endpackage

// ===== hdl/dfls_ctrl.sv =====
// Walk sequencer of the decision forest leaf search block.
// Depends on dfls_pkg; drives dfls_datapath through ctrl_cmd_t.
module dfls_ctrl #(
	parameter int SAMPLE_WORDS = dfls_pkg::SAMPLE_WORDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  dfls_pkg::func_t       func,
	input  dfls_pkg::ctrl_status_t status,
	output dfls_pkg::ctrl_cmd_t   cmd,
	output logic                  busy,
	output logic                  rsp_valid
);
	import dfls_pkg::*;

	localparam int MOD_STEPS = mod_steps(SAMPLE_WORDS);
	localparam int STEP_W    = (MOD_STEPS < 2) ? 1 : $clog2(MOD_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'((MOD_STEPS > 0) ? MOD_STEPS - 1 : 0);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;

	// Hold state and fold step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ADDR) begin
				step_q <= '0;
			end else if (state_q == ST_MOD) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		rsp_valid = 1'b0;
		cmd.accept = start && !busy;
		case (state_q)
			ST_IDLE: begin
				if (start && func == FUNC_EVALUATE) begin
					cmd.eval_load = 1'b1;
					state_d       = ST_NODE_RD;
				end
			end
			ST_NODE_RD: begin
				cmd.node_rd = 1'b1;
				state_d     = ST_NODE_CHK;
			end
			ST_NODE_CHK: begin
				if (status.is_leaf) begin
					state_d = ST_DONE;
				end else if (status.depth_hit) begin
					cmd.set_ovr = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.off_rd = 1'b1;
					state_d    = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.addr_init = 1'b1;
				state_d       = (MOD_STEPS > 0) ? ST_MOD : ST_SMP_RD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (step_q == LAST_STEP) state_d = ST_SMP_RD;
			end
			ST_SMP_RD: begin
				cmd.smp_rd = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				cmd.advance = 1'b1;
				state_d     = ST_NODE_RD;
			end
			ST_DONE: begin
				rsp_valid = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/dfls_datapath.sv =====
// Stores, configuration registers and walk arithmetic of the leaf search block.
// Depends on dfls_pkg; sequenced by dfls_ctrl through ctrl_cmd_t.
module dfls_datapath #(
	parameter int NODE_SLOTS    = dfls_pkg::NODE_SLOTS_DEF,
	parameter int FEATURE_SLOTS = dfls_pkg::FEATURE_SLOTS_DEF,
	parameter int SAMPLE_WORDS  = dfls_pkg::SAMPLE_WORDS_DEF,
	parameter int MAX_DEPTH     = dfls_pkg::MAX_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dfls_pkg::req_t                     req,
	input  dfls_pkg::ctrl_cmd_t                cmd,
	output dfls_pkg::ctrl_status_t             status,
	output dfls_pkg::rsp_t                     rsp,
	input  logic                               cfg_we,
	input  dfls_pkg::cfg_reg_t                 cfg_index,
	input  logic [dfls_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dfls_pkg::*;

	localparam int NAW = (NODE_SLOTS < 2) ? 1 : $clog2(NODE_SLOTS);
	localparam int FAW = (FEATURE_SLOTS < 2) ? 1 : $clog2(FEATURE_SLOTS);
	localparam int SAW = (SAMPLE_WORDS < 2) ? 1 : $clog2(SAMPLE_WORDS);
	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int MOD_STEPS = mod_steps(SAMPLE_WORDS);
	localparam longint DIV_WIDE =
		longint'(SAMPLE_WORDS) << ((MOD_STEPS > 0) ? MOD_STEPS - 1 : 0);
	localparam logic [SUM_W-1:0] DIV_INIT = (MOD_STEPS > 0) ? SUM_W'(DIV_WIDE) : '0;
	localparam logic [6:0] TREE_MOD = 7'(TREE_COUNT);

	// Stores
	node_t              node_mem [NODE_SLOTS];
	offset_t            off_mem  [FEATURE_SLOTS];
	logic signed [23:0] ch_mem   [SAMPLE_WORDS];
	logic signed [23:0] sim_mem  [SAMPLE_WORDS];

	// Configuration
	logic [15:0] npt_q;
	logic [11:0] cff_q;

	// Walk registers
	logic [15:0]        base_q;
	logic [15:0]        k_q;
	logic [17:0]        patch_q;
	logic [DW-1:0]      moves_q;
	logic               ovr_q;
	node_t              node_q;
	logic               node_ok_q;
	offset_t            off_q;
	logic               feat_ok_q;
	logic               chan_q;
	logic [SUM_W-1:0]   sa_q, sb_q, div_q;
	logic signed [23:0] ch_q, sma_q, smb_q;

	// Request decode
	logic [31:0]      node_idx_w, feat_idx_w, smp_idx_w;
	logic             node_wr, off_wr, smp_wr;
	logic [6:0]       tree_mod;
	logic [22:0]      base_prod;
	logic [31:0]      k_w, feat_w, sa_w, sb_w;
	logic [11:0]      feat;
	logic [17:0]      oa_eff, ob_eff;
	logic signed [24:0] ftr, thr_x;
	logic             go_left;
	logic [15:0]      local_k;

	assign node_idx_w = {16'd0, req.node_index};
	assign feat_idx_w = {20'd0, req.feature_id};
	assign smp_idx_w  = {14'd0, req.sample_address};
	assign node_wr = cmd.accept && req.func == FUNC_LOAD_NODE && node_idx_w < 32'(NODE_SLOTS);
	assign off_wr  = cmd.accept && req.func == FUNC_LOAD_OFFSETS &&
		feat_idx_w < 32'(FEATURE_SLOTS);
	assign smp_wr  = cmd.accept && req.func == FUNC_WRITE_SAMPLE &&
		smp_idx_w < 32'(SAMPLE_WORDS);

	// Fold tree index into the tree count
	always_comb begin
		tree_mod = {4'd0, req.tree_index};
		for (int i = 0; i < 8; i++) begin
			if (tree_mod >= TREE_MOD) tree_mod = tree_mod - TREE_MOD;
		end
	end

	assign base_prod = 23'(tree_mod) * 23'(npt_q);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npt_q <= 16'd8192;
			cff_q <= 12'd3000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODES_PER_TREE:   npt_q <= cfg_data;
				CFG_CHANNEL_FEATURES: cff_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Load node and offset stores
	always_ff @(posedge clk) begin
		if (node_wr) begin
			node_mem[node_idx_w[NAW-1:0]] <= '{child: req.child_link,
				feat: req.feature_id, thr: req.threshold};
		end
		if (off_wr) begin
			off_mem[feat_idx_w[FAW-1:0]] <= '{a: req.offset_a, b: req.offset_b};
		end
	end

	// Write samples
	always_ff @(posedge clk) begin
		if (smp_wr && !req.sample_select) ch_mem[smp_idx_w[SAW-1:0]] <= req.sample_value;
		if (smp_wr && req.sample_select) sim_mem[smp_idx_w[SAW-1:0]] <= req.sample_value;
	end

	// Read node at current slot
	assign k_w = {16'd0, k_q};
	always_ff @(posedge clk) begin
		if (cmd.node_rd) begin
			node_q    <= node_mem[k_w[NAW-1:0]];
			node_ok_q <= k_w < 32'(NODE_SLOTS);
		end
	end

	assign status.is_leaf   = !node_ok_q || node_q.child == 16'd0;
	assign status.depth_hit = moves_q >= DW'(MAX_DEPTH);

	// Read offset pair of the node's feature
	assign feat   = node_q.feat;
	assign feat_w = {20'd0, feat};
	always_ff @(posedge clk) begin
		if (cmd.off_rd) begin
			off_q     <= off_mem[feat_w[FAW-1:0]];
			feat_ok_q <= feat_w < 32'(FEATURE_SLOTS);
			chan_q    <= feat < cff_q;
		end
	end

	// Form sample addresses and fold them below the sample depth
	assign oa_eff = feat_ok_q ? off_q.a : 18'd0;
	assign ob_eff = feat_ok_q ? off_q.b : 18'd0;
	always_ff @(posedge clk) begin
		if (cmd.addr_init) begin
			sa_q  <= {1'b0, oa_eff} + {1'b0, patch_q};
			sb_q  <= {1'b0, ob_eff} + {1'b0, patch_q};
			div_q <= DIV_INIT;
		end else if (cmd.mod_step) begin
			if (sa_q >= div_q) sa_q <= sa_q - div_q;
			if (sb_q >= div_q) sb_q <= sb_q - div_q;
			div_q <= div_q >> 1;
		end
	end

	// Read samples
	assign sa_w = {13'd0, sa_q};
	assign sb_w = {13'd0, sb_q};
	always_ff @(posedge clk) begin
		if (cmd.smp_rd) begin
			ch_q  <= ch_mem[sa_w[SAW-1:0]];
			sma_q <= sim_mem[sa_w[SAW-1:0]];
			smb_q <= sim_mem[sb_w[SAW-1:0]];
		end
	end

	// Compare feature with threshold and pick child
	assign ftr     = chan_q ? {ch_q[23], ch_q} : ({sma_q[23], sma_q} - {smb_q[23], smb_q});
	assign thr_x   = {node_q.thr[23], node_q.thr};
	assign go_left = ftr < thr_x;
	assign local_k = go_left ? node_q.child - 16'd1 : node_q.child;

	// Advance walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moves_q <= '0;
			ovr_q   <= 1'b0;
		end else if (cmd.eval_load) begin
			moves_q <= '0;
			ovr_q   <= 1'b0;
		end else begin
			if (cmd.advance) moves_q <= moves_q + 1'b1;
			if (cmd.set_ovr) ovr_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_load) begin
			base_q  <= base_prod[15:0];
			k_q     <= base_prod[15:0];
			patch_q <= req.patch_offset;
		end else if (cmd.advance) begin
			k_q <= local_k + base_q;
		end
	end

	assign rsp.leaf_index    = k_q;
	assign rsp.depth_overrun = ovr_q;

endmodule

// ===== hdl/decision_forest_leaf_search.sv =====
// Top level of the decision forest leaf search block: sequencer plus datapath.
// Depends on dfls_pkg, dfls_ctrl and dfls_datapath.
//
//   channel   signals                              moves
//   request   start, busy, req                     load node/offsets/sample, or evaluate
//   result    rsp_valid, rsp                       leaf index and depth overrun flag
//   config    cfg_valid, cfg_ready, cfg_index,     nodes_per_tree, channel_feature_count
//             cfg_data
//
// Loads leave busy low. An evaluate request keeps busy high through its walk,
// which is at most MAX_DEPTH moves long; each move reads the node store, the
// offset store and the sample stores one after another, with S subtract steps
// between the offset and sample reads that fold a sample address below
// SAMPLE_WORDS (S is 1 at the default size).
// Reset clears the sequencer and sets the configuration to its defaults; stores are undefined until written.
// The result is shown for one cycle and the receiver cannot stall it.
module decision_forest_leaf_search #(
	parameter int NODE_SLOTS    = dfls_pkg::NODE_SLOTS_DEF,
	parameter int FEATURE_SLOTS = dfls_pkg::FEATURE_SLOTS_DEF,
	parameter int SAMPLE_WORDS  = dfls_pkg::SAMPLE_WORDS_DEF,
	parameter int MAX_DEPTH     = dfls_pkg::MAX_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  dfls_pkg::req_t                  req,
	output logic                            rsp_valid,
	output dfls_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  dfls_pkg::cfg_reg_t              cfg_index,
	input  logic [dfls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dfls_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	dfls_ctrl #(
		.SAMPLE_WORDS(SAMPLE_WORDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (req.func),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.rsp_valid (rsp_valid)
	);

	dfls_datapath #(
		.NODE_SLOTS   (NODE_SLOTS),
		.FEATURE_SLOTS(FEATURE_SLOTS),
		.SAMPLE_WORDS (SAMPLE_WORDS),
		.MAX_DEPTH    (MAX_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.status   (status),
		.rsp      (rsp),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// An evaluate request starts a walk
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.func == FUNC_EVALUATE) |=> busy)
		else $error("evaluate request did not start a walk");

	// The block is idle after a result
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !busy)
		else $error("block still busy after result");

	// An overrun result stands at the depth bound
	a_ovr_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.depth_overrun) |-> status.depth_hit)
		else $error("depth overrun reported below depth bound");

	// A plain result stands on a leaf
	a_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.depth_overrun) |-> status.is_leaf)
		else $error("result reported at an inner node");

endmodule
